/* hw/rtl/btm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btm_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_LOAD       = 3'd1,
        OP_RESERVE    = 3'd2,
        OP_SET_STOP   = 3'd3,
        OP_CLR_STOP   = 3'd4,
        OP_SLOT_CHECK = 3'd5,
        OP_STOP_CHECK = 3'd6,
        OP_QUERY      = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [4:0]  template_index;
        logic [1:0]  slot;
        logic [7:0]  property_req;
        logic        stop_flag;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [4:0]  template_code;
        logic        is_full;
        logic        is_empty;
        logic        has_property;
        logic [23:0] slot_mask;
    } t_out_word;

endpackage

`default_nettype wire

/* hw/rtl/btm_tmpl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module btm_tmpl_ram #(
    parameter int DEPTH  = 32,
    parameter int LANES  = 3,
    parameter int LANE_W = 9,
    parameter int ADDR_W = 5
) (
    input  wire logic                          i_clk,
    input  wire logic [LANES-1:0]              i_we,
    input  wire logic [ADDR_W-1:0]             i_waddr,
    input  wire logic [LANE_W-1:0]             i_wdata,
    input  wire logic                          i_re,
    input  wire logic [ADDR_W-1:0]             i_raddr,
    output logic      [LANES-1:0][LANE_W-1:0]  o_rdata
);

    logic [LANES-1:0][LANE_W-1:0] r_mem [DEPTH];
    logic [LANES-1:0][LANE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LANES; j++) begin
            if (i_we[j]) begin
                r_mem[i_waddr][j] <= i_wdata;
            end
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/bundle_template_matcher.sv */
// Non-check words: the result word is loaded into the output register from the done state,
// and a new input word is accepted only after the previous result word has been loaded.
// Checks read one template row per cycle from the template table memory and stop at the
// first matching row or after the last row; the result word is then loaded the same way.
// A new word may be accepted while the previous result word waits.
// Synchronous active-low reset clears the bundle, the chosen template and the packed mask;
// the template table is not cleared and must be loaded before any check.
`timescale 1ns / 1ps
`default_nettype none

module bundle_template_matcher
    import btm_pkg::*;
#(
    parameter int NUM_TEMPLATES = 32,
    parameter int NUM_SLOTS     = 3,
    parameter int PROP_BITS     = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int TI_W  = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
    localparam int CNT_W = $clog2(NUM_TEMPLATES + 1);
    localparam int PK_W  = NUM_SLOTS * PROP_BITS;
    localparam int ENT_W = PROP_BITS + 1;

    function automatic logic fits(input logic [PROP_BITS-1:0] p,
                                  input logic [PROP_BITS-1:0] t);
        return (p == '0) || ((p & t) == t);
    endfunction

    t_state                      r_state, n_state;
    logic [NUM_SLOTS-1:0]        r_filled;
    logic [NUM_SLOTS-1:0]        r_stops;
    logic [PROP_BITS-1:0]        r_props [NUM_SLOTS];
    logic [4:0]                  r_chosen;
    logic [PK_W-1:0]             r_packed;
    logic                        r_found;
    t_opcode                     r_op;
    logic [1:0]                  r_slot;
    logic [PROP_BITS-1:0]        r_prop;
    logic [CNT_W-1:0]            r_issue;
    logic                        r_dvalid;
    logic [TI_W-1:0]             r_didx;
    logic                        r_out_valid;
    t_out_word                   r_out_word;

    logic                        acc;
    logic                        slot_ok;
    logic                        ti_ok;
    logic [PROP_BITS-1:0]        in_prop;
    logic                        is_check;
    logic [NUM_SLOTS-1:0]        we_lane;
    logic                        rd_en;
    logic [NUM_SLOTS-1:0][ENT_W-1:0] rd_row;
    logic [NUM_SLOTS-1:0]        lane_ok;
    logic                        hit;
    logic                        last;
    logic                        out_load;
    logic                        hasp;

    assign in_prop  = PROP_BITS'(i_in_word.property_req);
    assign slot_ok  = 32'(i_in_word.slot) < NUM_SLOTS;
    assign ti_ok    = 32'(i_in_word.template_index) < NUM_TEMPLATES;
    assign is_check = (i_in_word.opcode == OP_SLOT_CHECK) ||
                      (i_in_word.opcode == OP_STOP_CHECK);
    assign acc      = i_in_valid && o_in_ready;

    always_comb begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
            we_lane[j] = acc && (i_in_word.opcode == OP_LOAD) && slot_ok && ti_ok &&
                         (32'(i_in_word.slot) == j);
        end
    end

    btm_tmpl_ram #(
        .DEPTH  (NUM_TEMPLATES),
        .LANES  (NUM_SLOTS),
        .LANE_W (ENT_W),
        .ADDR_W (TI_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we_lane),
        .i_waddr (TI_W'(i_in_word.template_index)),
        .i_wdata ({i_in_word.stop_flag, in_prop}),
        .i_re    (rd_en),
        .i_raddr (r_issue[TI_W-1:0]),
        .o_rdata (rd_row)
    );

    always_comb begin
        logic                 is_s;
        logic [PROP_BITS-1:0] tprop;
        logic                 tstop;
        logic [PROP_BITS-1:0] p;
        logic                 sv;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            is_s  = 32'(r_slot) == j;
            tprop = rd_row[j][PROP_BITS-1:0];
            tstop = rd_row[j][PROP_BITS];
            p     = is_s ? r_prop : r_props[j];
            sv    = is_s ? 1'b1 : r_stops[j];
            if (r_op == OP_SLOT_CHECK) begin
                lane_ok[j] = !(is_s || r_filled[j] || r_stops[j]) ||
                             (fits(p, tprop) && (r_stops[j] == tstop));
            end else begin
                lane_ok[j] = (tstop == sv) && (!r_filled[j] || fits(r_props[j], tprop));
            end
        end
    end

    assign hit  = r_dvalid && (&lane_ok);
    assign last = r_dvalid && (r_didx == TI_W'(NUM_TEMPLATES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_state = (is_check && slot_ok) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
            end
            ST_SCAN: begin
                rd_en = r_issue < CNT_W'(NUM_TEMPLATES);
            end
            ST_DONE: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_stops  <= '0;
            r_chosen <= '0;
            r_packed <= '0;
            r_found  <= 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                r_props[j] <= '0;
            end
        end else begin
            if (acc) begin
                r_found <= 1'b0;
                unique case (i_in_word.opcode)
                    OP_CLEAR: begin
                        r_filled <= '0;
                        r_stops  <= '0;
                        r_chosen <= '0;
                        r_packed <= '0;
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            r_props[j] <= '0;
                        end
                    end
                    OP_RESERVE: begin
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (32'(i_in_word.slot) == j) begin
                                r_filled[j] <= 1'b1;
                                r_props[j]  <= in_prop;
                                r_packed[PROP_BITS*(NUM_SLOTS-1-j) +: PROP_BITS] <=
                                    r_packed[PROP_BITS*(NUM_SLOTS-1-j) +: PROP_BITS] | in_prop;
                            end
                        end
                    end
                    OP_SET_STOP: begin
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (32'(i_in_word.slot) == j) begin
                                r_stops[j] <= 1'b1;
                            end
                        end
                    end
                    OP_CLR_STOP: begin
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (32'(i_in_word.slot) == j) begin
                                r_stops[j] <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_SCAN && hit) begin
                r_found  <= 1'b1;
                r_chosen <= 5'(r_didx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op   <= i_in_word.opcode;
            r_slot <= i_in_word.slot;
            r_prop <= in_prop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
        end else if (acc) begin
            r_dvalid <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_dvalid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_issue <= '0;
        end else if (rd_en) begin
            r_issue <= r_issue + CNT_W'(1);
            r_didx  <= r_issue[TI_W-1:0];
        end
    end

    always_comb begin
        hasp = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            hasp = hasp | (|(r_props[j] & r_prop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.found         <= r_found;
            r_out_word.template_code <= r_chosen;
            r_out_word.is_full       <= &r_filled;
            r_out_word.is_empty      <= ~|r_filled;
            r_out_word.has_property  <= hasp;
            r_out_word.slot_mask     <= 24'(r_packed);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_found_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_found) |-> (r_op == OP_SLOT_CHECK || r_op == OP_STOP_CHECK))
        else $error("found set for an operation that is not a check");

    a_no_read_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && (|we_lane)))
        else $error("template table read and written in the same cycle");

    a_hit_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && hit) |=> (r_state == ST_DONE && r_found))
        else $error("matching template did not end the scan");

    a_scan_reads_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_dvalid) |-> $past(rd_en))
        else $error("row evaluated without a preceding read");

endmodule

`default_nettype wire

/* test/bundle_template_matcher_tb.sv */
`timescale 1ns / 1ps

module bundle_template_matcher_tb;
    import btm_pkg::*;

    localparam int N_TPL    = 32;
    localparam int N_SLOT   = 3;
    localparam int N_RANDOM = 1680;
    localparam int TAIL_LEN = 150;

    typedef struct {
        t_in_word w;
        bit       drain;
    } t_pending_op;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_pending_op op_queue[$];
    t_out_word   bundle_reports[$];
    t_out_word   due_word;

    logic [7:0]  tpl_prop [N_TPL * N_SLOT];
    logic        tpl_stop [N_TPL * N_SLOT];
    logic        bnd_used [N_SLOT];
    logic [7:0]  bnd_prop [N_SLOT];
    logic        bnd_stop [N_SLOT];
    logic [4:0]  chosen = '0;
    logic [23:0] packed_props = '0;

    int n_items = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_checks = 0;
    int n_hits = 0;
    int in_gap = 0;
    int out_stall = 0;
    logic tail;

    assign tail = (n_accepted + TAIL_LEN >= n_items);

    bundle_template_matcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    function automatic bit prop_fits(logic [7:0] p, logic [7:0] tp);
        return (p == 8'd0) || ((p & tp) == tp);
    endfunction

    function automatic void clear_bundle();
        for (int j = 0; j < N_SLOT; j++) begin
            bnd_used[j] = 1'b0;
            bnd_prop[j] = '0;
            bnd_stop[j] = 1'b0;
        end
        chosen = '0;
        packed_props = '0;
    endfunction

    function automatic t_out_word bundle_update(t_in_word w);
        t_out_word  r;
        bit         ok;
        bit         hit;
        int         e;
        int         s;
        logic [7:0] p;
        logic       sv;
        r = '0;
        hit = 1'b0;
        s = int'(w.slot);
        case (w.opcode)
            OP_CLEAR: begin
                clear_bundle();
            end
            OP_LOAD: begin
                if (s < N_SLOT && int'(w.template_index) < N_TPL) begin
                    e = int'(w.template_index) * N_SLOT + s;
                    tpl_prop[e] = w.property_req;
                    tpl_stop[e] = w.stop_flag;
                end
            end
            OP_RESERVE: begin
                if (s < N_SLOT) begin
                    bnd_used[s] = 1'b1;
                    bnd_prop[s] = w.property_req;
                    packed_props = packed_props
                                   | (24'(w.property_req) << (8 * (N_SLOT - 1 - s)));
                end
            end
            OP_SET_STOP: begin
                if (s < N_SLOT) bnd_stop[s] = 1'b1;
            end
            OP_CLR_STOP: begin
                if (s < N_SLOT) bnd_stop[s] = 1'b0;
            end
            OP_SLOT_CHECK: begin
                if (s < N_SLOT) begin
                    for (int t = 0; t < N_TPL && !hit; t++) begin
                        ok = 1'b1;
                        for (int j = 0; j < N_SLOT; j++) begin
                            e = t * N_SLOT + j;
                            p = (j == s) ? w.property_req : bnd_prop[j];
                            if ((j == s || bnd_used[j] || bnd_stop[j])
                                && (!prop_fits(p, tpl_prop[e]) || bnd_stop[j] != tpl_stop[e]))
                                ok = 1'b0;
                        end
                        if (ok) begin
                            hit = 1'b1;
                            chosen = 5'(t);
                        end
                    end
                end
            end
            OP_STOP_CHECK: begin
                if (s < N_SLOT) begin
                    for (int t = 0; t < N_TPL && !hit; t++) begin
                        ok = 1'b1;
                        for (int j = 0; j < N_SLOT; j++) begin
                            e = t * N_SLOT + j;
                            sv = (j == s) ? 1'b1 : bnd_stop[j];
                            if (tpl_stop[e] != sv)
                                ok = 1'b0;
                            else if (bnd_used[j] && !prop_fits(bnd_prop[j], tpl_prop[e]))
                                ok = 1'b0;
                        end
                        if (ok) begin
                            hit = 1'b1;
                            chosen = 5'(t);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.found = hit;
        r.template_code = chosen;
        r.is_full = 1'b1;
        r.is_empty = 1'b1;
        r.has_property = 1'b0;
        for (int j = 0; j < N_SLOT; j++) begin
            if (bnd_used[j]) r.is_empty = 1'b0;
            else r.is_full = 1'b0;
            if ((bnd_prop[j] & w.property_req) != 8'd0) r.has_property = 1'b1;
        end
        r.slot_mask = packed_props;
        return r;
    endfunction

    function automatic t_in_word make_word(t_opcode op, int idx, int sl, int prop, bit sf);
        t_in_word w;
        w.opcode = op;
        w.template_index = 5'(idx);
        w.slot = 2'(sl);
        w.property_req = 8'(prop);
        w.stop_flag = sf;
        return w;
    endfunction

    function automatic void add_op(t_in_word w, bit drain);
        t_pending_op po;
        po.w = w;
        po.drain = drain;
        op_queue.push_back(po);
    endfunction

    function automatic int rand_prop();
        int k;
        k = $urandom_range(0, 99);
        if (k < 25) return 0;
        if (k < 65) return 1 << $urandom_range(0, 7);
        if (k < 80) return (1 << $urandom_range(0, 7)) | (1 << $urandom_range(0, 7));
        return $urandom_range(0, 255);
    endfunction

    function automatic int rand_slot();
        return ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
    endfunction

    function automatic t_in_word rand_word();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5) begin
            return make_word(t_opcode'($urandom_range(0, 7)), $urandom_range(0, 31),
                             $urandom_range(0, 3), $urandom_range(0, 255),
                             1'($urandom_range(0, 1)));
        end
        if (k < 13) begin
            return make_word(OP_LOAD, $urandom_range(0, 31), rand_slot(), rand_prop(),
                             $urandom_range(0, 3) == 0);
        end
        if (k < 38) return make_word(OP_RESERVE, 0, rand_slot(), rand_prop(), 1'b0);
        if (k < 46) return make_word(OP_SET_STOP, 0, rand_slot(), rand_prop(), 1'b0);
        if (k < 53) return make_word(OP_CLR_STOP, 0, rand_slot(), rand_prop(), 1'b0);
        if (k < 75) return make_word(OP_SLOT_CHECK, 0, rand_slot(), rand_prop(), 1'b0);
        if (k < 88) return make_word(OP_STOP_CHECK, 0, rand_slot(), rand_prop(), 1'b0);
        if (k < 95) return make_word(OP_QUERY, 0, rand_slot(), $urandom_range(0, 255), 1'b0);
        return make_word(OP_CLEAR, $urandom_range(0, 31), rand_slot(), rand_prop(), 1'b0);
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                bundle_reports.push_back(bundle_update(in_word));
                n_accepted <= n_accepted + 1;
                if (in_word.opcode == OP_SLOT_CHECK || in_word.opcode == OP_STOP_CHECK)
                    n_checks++;
            end
            if (!in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (op_queue.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (op_queue[0].drain && (in_valid || n_results != n_accepted)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_word <= op_queue[0].w;
                    void'(op_queue.pop_front());
                    if (!tail && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            out_ready <= 1'b1;
            if (!tail && $urandom_range(0, 7) == 0) out_stall <= $urandom_range(1, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (n_results >= n_accepted) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result word %h at %0t ns.", o_out_word, $time);
            end else begin
                due_word = bundle_reports.pop_front();
                n_results <= n_results + 1;
                if (due_word.found) n_hits++;
                if (o_out_word.found !== due_word.found
                    || o_out_word.template_code !== due_word.template_code
                    || o_out_word.is_full !== due_word.is_full
                    || o_out_word.is_empty !== due_word.is_empty
                    || o_out_word.has_property !== due_word.has_property
                    || o_out_word.slot_mask !== due_word.slot_mask) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Word %0d mismatch: expected found=%b code=%0d full=%b",
                                 n_results, due_word.found, due_word.template_code,
                                 due_word.is_full);
                        $display("  empty=%b has_prop=%b mask=%06h; got found=%b code=%0d",
                                 due_word.is_empty, due_word.has_property,
                                 due_word.slot_mask, o_out_word.found,
                                 o_out_word.template_code);
                        $display("  full=%b empty=%b has_prop=%b mask=%06h",
                                 o_out_word.is_full, o_out_word.is_empty,
                                 o_out_word.has_property, o_out_word.slot_mask);
                    end
                end
            end
        end
    end

    initial begin
        int len;
        for (int e = 0; e < N_TPL * N_SLOT; e++) begin
            tpl_prop[e] = '0;
            tpl_stop[e] = 1'b0;
        end
        clear_bundle();

        // The whole template table is written before the first check.
        for (int t = 0; t < N_TPL; t++) begin
            for (int j = 0; j < N_SLOT; j++) begin
                len = $urandom_range(0, 9);
                add_op(make_word(OP_LOAD, t, j,
                                 (len < 4) ? 0 : (len < 8) ? (1 << $urandom_range(0, 7))
                                                           : $urandom_range(0, 255),
                                 $urandom_range(0, 3) == 0), 1'b0);
            end
        end

        add_op(make_word(OP_QUERY, 0, 0, 8'hFF, 1'b0), 1'b0);
        add_op(make_word(OP_LOAD, 31, 3, 8'hFF, 1'b1), 1'b0);
        add_op(make_word(OP_RESERVE, 0, 3, 8'hFF, 1'b0), 1'b0);
        add_op(make_word(OP_SET_STOP, 0, 3, 0, 1'b0), 1'b0);
        add_op(make_word(OP_CLR_STOP, 0, 3, 0, 1'b0), 1'b0);
        add_op(make_word(OP_SLOT_CHECK, 0, 3, 8'h01, 1'b0), 1'b0);
        add_op(make_word(OP_STOP_CHECK, 0, 3, 0, 1'b0), 1'b0);
        add_op(make_word(OP_SLOT_CHECK, 0, 0, 8'h00, 1'b0), 1'b0);
        add_op(make_word(OP_RESERVE, 0, 0, 8'hFF, 1'b0), 1'b0);
        add_op(make_word(OP_RESERVE, 0, 1, 8'h00, 1'b0), 1'b0);
        add_op(make_word(OP_RESERVE, 0, 2, 8'h81, 1'b0), 1'b0);
        add_op(make_word(OP_RESERVE, 0, 2, 8'h7E, 1'b0), 1'b0);
        add_op(make_word(OP_QUERY, 31, 3, 8'hFF, 1'b1), 1'b0);
        add_op(make_word(OP_QUERY, 0, 0, 8'h00, 1'b0), 1'b0);
        add_op(make_word(OP_SLOT_CHECK, 0, 1, 8'hFF, 1'b0), 1'b0);
        add_op(make_word(OP_STOP_CHECK, 0, 2, 0, 1'b0), 1'b0);
        add_op(make_word(OP_SET_STOP, 0, 1, 0, 1'b0), 1'b0);
        add_op(make_word(OP_SLOT_CHECK, 0, 1, 8'h01, 1'b0), 1'b0);
        add_op(make_word(OP_STOP_CHECK, 0, 0, 0, 1'b0), 1'b0);
        add_op(make_word(OP_SLOT_CHECK, 0, 2, 8'h80, 1'b0), 1'b0);
        add_op(make_word(OP_CLR_STOP, 0, 1, 0, 1'b0), 1'b0);
        add_op(make_word(OP_STOP_CHECK, 0, 1, 0, 1'b0), 1'b0);
        add_op(make_word(OP_CLEAR, 31, 3, 8'hFF, 1'b1), 1'b0);
        add_op(make_word(OP_QUERY, 0, 0, 8'hFF, 1'b0), 1'b0);

        // Each random sequence usually starts from an empty bundle.
        add_op(make_word(OP_CLEAR, 0, 0, 0, 1'b0), 1'b1);
        len = op_queue.size() + N_RANDOM;
        while (op_queue.size() < len) begin
            if ($urandom_range(0, 9) != 0) add_op(make_word(OP_CLEAR, 0, 0, 0, 1'b0), 1'b0);
            repeat ($urandom_range(2, 12)) add_op(rand_word(), $urandom_range(0, 149) == 0);
        end
        n_items = op_queue.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid || n_results != n_accepted) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Ran %0d words through the bundle, %0d of them template checks.",
                 n_accepted, n_checks);
        $display("%0d checks found a template; %0d mismatches were seen.", n_hits, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/btm_pkg.sv
hw/rtl/btm_tmpl_ram.sv
hw/rtl/bundle_template_matcher.sv
test/bundle_template_matcher_tb.sv
